[hw/rtl/cpu8alu_pkg.sv]
// ----------------------------------------------------------------------------
// cpu8alu_pkg
// Shared types and operation codes for the 8-bit CPU arithmetic and flag unit.
// ----------------------------------------------------------------------------
package cpu8alu_pkg;

    localparam int unsigned CMD_W  = 5;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned WIDE_W = 16;
    localparam int unsigned BIT_W  = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD   = 5'd0,
        CMD_ADC   = 5'd1,
        CMD_SUB   = 5'd2,
        CMD_SBC   = 5'd3,
        CMD_AND   = 5'd4,
        CMD_XOR   = 5'd5,
        CMD_OR    = 5'd6,
        CMD_CP    = 5'd7,
        CMD_INC   = 5'd8,
        CMD_DEC   = 5'd9,
        CMD_RLC   = 5'd10,
        CMD_RRC   = 5'd11,
        CMD_RL    = 5'd12,
        CMD_RR    = 5'd13,
        CMD_SLA   = 5'd14,
        CMD_SRA   = 5'd15,
        CMD_SWAP  = 5'd16,
        CMD_SRL   = 5'd17,
        CMD_BIT   = 5'd18,
        CMD_RES   = 5'd19,
        CMD_SET   = 5'd20,
        CMD_RLCA  = 5'd21,
        CMD_RRCA  = 5'd22,
        CMD_RLA   = 5'd23,
        CMD_RRA   = 5'd24,
        CMD_DAA   = 5'd25,
        CMD_CPL   = 5'd26,
        CMD_CCF   = 5'd27,
        CMD_SCF   = 5'd28,
        CMD_ADD16 = 5'd29,
        CMD_ADDSP = 5'd30
    } cmd_t;

    typedef struct packed {
        logic z;
        logic n;
        logic h;
        logic c;
    } flags_t;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [BYTE_W-1:0] acc;
        logic [BYTE_W-1:0] operand;
        logic [BIT_W-1:0]  bit_sel;
        logic [WIDE_W-1:0] wide_l;
        logic [WIDE_W-1:0] wide_r;
        flags_t            flags;
    } op_t;

    typedef struct packed {
        logic [BYTE_W-1:0] byte_res;
        logic              byte_wr;
        logic [WIDE_W-1:0] wide_res;
        flags_t            flags;
    } res_t;

endpackage

[hw/rtl/cpu8alu_core.sv]
// ----------------------------------------------------------------------------
// cpu8alu_core
// Combinational datapath: byte ALU, shifter, bit ops, DAA and 16-bit adds.
// ----------------------------------------------------------------------------
module cpu8alu_core
    import cpu8alu_pkg::*;
(
    input  op_t  op,
    output res_t res
);

    // Shift and rotate unit: returns {carry, result}
    function automatic logic [BYTE_W:0] shift_op(
        input logic [2:0]        k,
        input logic [BYTE_W-1:0] v,
        input logic              cin
    );
        logic [BYTE_W-1:0] r;
        logic              co;
        begin
            case (k)
                3'd0:
                begin
                    r  = {v[6:0], v[7]};
                    co = v[7];
                end
                3'd1:
                begin
                    r  = {v[0], v[7:1]};
                    co = v[0];
                end
                3'd2:
                begin
                    r  = {v[6:0], cin};
                    co = v[7];
                end
                3'd3:
                begin
                    r  = {cin, v[7:1]};
                    co = v[0];
                end
                3'd4:
                begin
                    r  = {v[6:0], 1'b0};
                    co = v[7];
                end
                3'd5:
                begin
                    r  = {v[7], v[7:1]};
                    co = v[0];
                end
                3'd6:
                begin
                    r  = {v[3:0], v[7:4]};
                    co = 1'b0;
                end
                default:
                begin
                    r  = {1'b0, v[7:1]};
                    co = v[0];
                end
            endcase
            shift_op = {co, r};
        end
    endfunction

    logic [BYTE_W-1:0] a;
    logic [BYTE_W-1:0] v;
    logic              cin;
    logic [BYTE_W:0]   sum9;
    logic [BYTE_W:0]   rhs9;
    logic [4:0]        nib_sum;
    logic [4:0]        nib_rhs;
    logic [BYTE_W:0]   sh;
    logic [BYTE_W-1:0] mask;
    logic [BYTE_W-1:0] corr;
    logic [WIDE_W:0]   sum17;
    logic [12:0]       sum13;
    logic [WIDE_W-1:0] ext;
    logic [BYTE_W-1:0] r;
    logic              wr;
    logic [WIDE_W-1:0] w;
    flags_t            f;

    always_comb
    begin
        a       = op.acc;
        v       = op.operand;
        cin     = ((op.cmd == CMD_ADC) || (op.cmd == CMD_SBC)) ? op.flags.c : 1'b0;
        sum9    = {1'b0, a} + {1'b0, v} + {8'd0, cin};
        rhs9    = {1'b0, v} + {8'd0, cin};
        nib_sum = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, cin};
        nib_rhs = {1'b0, v[3:0]} + {4'd0, cin};
        mask    = 8'd1 << op.bit_sel;
        sum17   = {1'b0, op.wide_l} + {1'b0, op.wide_r};
        sum13   = {1'b0, op.wide_l[11:0]} + {1'b0, op.wide_r[11:0]};
        ext     = {{8{v[7]}}, v};
        sh      = '0;
        corr    = '0;
        r       = '0;
        wr      = 1'b0;
        w       = '0;
        f       = op.flags;

        case (op.cmd)
            CMD_ADD, CMD_ADC:
            begin
                r   = sum9[7:0];
                f.h = nib_sum[4];
                f.c = sum9[8];
                f.n = 1'b0;
                f.z = (r == '0);
                wr  = 1'b1;
            end
            CMD_SUB, CMD_SBC, CMD_CP:
            begin
                r   = a - v - {7'd0, cin};
                f.h = ({1'b0, a[3:0]} < nib_rhs);
                f.c = ({1'b0, a} < rhs9);
                f.n = 1'b1;
                f.z = (r == '0);
                wr  = (op.cmd != CMD_CP);
                // compare keeps flags only
                if (op.cmd == CMD_CP)
                begin
                    r = '0;
                end
            end
            CMD_AND:
            begin
                r   = a & v;
                f   = '{z: (r == '0), n: 1'b0, h: 1'b1, c: 1'b0};
                wr  = 1'b1;
            end
            CMD_XOR:
            begin
                r   = a ^ v;
                f   = '{z: (r == '0), n: 1'b0, h: 1'b0, c: 1'b0};
                wr  = 1'b1;
            end
            CMD_OR:
            begin
                r   = a | v;
                f   = '{z: (r == '0), n: 1'b0, h: 1'b0, c: 1'b0};
                wr  = 1'b1;
            end
            CMD_INC:
            begin
                r   = v + 8'd1;
                f.z = (r == '0);
                f.n = 1'b0;
                f.h = (v[3:0] == 4'hF);
                wr  = 1'b1;
            end
            CMD_DEC:
            begin
                r   = v - 8'd1;
                f.z = (r == '0);
                f.n = 1'b1;
                f.h = (v[3:0] == 4'h0);
                wr  = 1'b1;
            end
            CMD_RLC, CMD_RRC, CMD_RL, CMD_RR, CMD_SLA, CMD_SRA, CMD_SWAP, CMD_SRL:
            begin
                sh  = shift_op(3'(op.cmd - CMD_RLC), v, op.flags.c);
                r   = sh[7:0];
                f   = '{z: (r == '0), n: 1'b0, h: 1'b0, c: sh[8]};
                wr  = 1'b1;
            end
            CMD_BIT:
            begin
                f.z = ~v[op.bit_sel];
                f.n = 1'b0;
                f.h = 1'b1;
            end
            CMD_RES:
            begin
                r  = v & ~mask;
                wr = 1'b1;
            end
            CMD_SET:
            begin
                r  = v | mask;
                wr = 1'b1;
            end
            CMD_RLCA, CMD_RRCA, CMD_RLA, CMD_RRA:
            begin
                sh  = shift_op(3'(op.cmd - CMD_RLCA), a, op.flags.c);
                r   = sh[7:0];
                f   = '{z: 1'b0, n: 1'b0, h: 1'b0, c: sh[8]};
                wr  = 1'b1;
            end
            CMD_DAA:
            begin
                if (!op.flags.n)
                begin
                    if (op.flags.h || (a[3:0] > 4'h9))
                    begin
                        corr = corr | 8'h06;
                    end
                    if (op.flags.c || (a > 8'h99))
                    begin
                        corr = corr | 8'h60;
                        f.c  = 1'b1;
                    end
                    r = a + corr;
                end
                else
                begin
                    if (op.flags.h)
                    begin
                        corr = corr | 8'h06;
                    end
                    if (op.flags.c)
                    begin
                        corr = corr | 8'h60;
                    end
                    r = a - corr;
                end
                f.z = (r == '0);
                f.h = 1'b0;
                wr  = 1'b1;
            end
            CMD_CPL:
            begin
                r   = ~a;
                f.n = 1'b1;
                f.h = 1'b1;
                wr  = 1'b1;
            end
            CMD_CCF:
            begin
                f.c = ~op.flags.c;
                f.n = 1'b0;
                f.h = 1'b0;
            end
            CMD_SCF:
            begin
                f.c = 1'b1;
                f.n = 1'b0;
                f.h = 1'b0;
            end
            CMD_ADD16:
            begin
                w   = sum17[15:0];
                f.h = sum13[12];
                f.c = sum17[16];
                f.n = 1'b0;
            end
            CMD_ADDSP:
            begin
                // carries come from the unsigned low byte, sum uses the signed offset
                w   = op.wide_l + ext;
                f.h = ({1'b0, op.wide_l[3:0]} + {1'b0, v[3:0]}) > 5'h0F;
                f.c = ({1'b0, op.wide_l[7:0]} + {1'b0, v}) > 9'h0FF;
                f.z = 1'b0;
                f.n = 1'b0;
            end
            default:
            begin
                f = op.flags;
            end
        endcase

        res.byte_res = r;
        res.byte_wr  = wr;
        res.wide_res = w;
        res.flags    = f;
    end

endmodule

[hw/rtl/cpu8_alu_flag_unit.sv]
// ----------------------------------------------------------------------------
// cpu8_alu_flag_unit
// Arithmetic and flag unit of an 8-bit CPU, two register stages.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one operation: cmd, the
//   accumulator, an operand byte, a bit number, two 16-bit operands and the
//   incoming Z/N/H/C flags. Output channel (out_valid/out_ready) returns one
//   transaction per input: byte_result with byte_write, wide_result and the
//   new flags.
//   The path runs through the input register, then the result register;
//   out_valid rises once the transaction moves into the result register.
//   Throughput: one transaction per cycle while out_ready is held high;
//   the datapath between the two registers is a few 8/16-bit adds and
//   compares plus result selection.
//   A stalled receiver holds the result register; the input register still
//   takes one more transaction, after which in_ready drops until out_ready
//   returns. Reset clears both valid bits; no transaction is lost or
//   duplicated across a stall.
// ----------------------------------------------------------------------------
module cpu8_alu_flag_unit
    import cpu8alu_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [CMD_W-1:0]  cmd,
    input  logic [BYTE_W-1:0] acc_in,
    input  logic [BYTE_W-1:0] operand_byte,
    input  logic [BIT_W-1:0]  bit_select,
    input  logic [WIDE_W-1:0] wide_left,
    input  logic [WIDE_W-1:0] wide_right,
    input  logic              zero_in,
    input  logic              sub_in,
    input  logic              half_in,
    input  logic              carry_in,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [BYTE_W-1:0] byte_result,
    output logic              byte_write,
    output logic [WIDE_W-1:0] wide_result,
    output logic              zero_out,
    output logic              sub_out,
    output logic              half_out,
    output logic              carry_out
);

    logic s1_valid_reg;
    logic s1_valid_next;
    logic s2_valid_reg;
    logic s2_valid_next;
    op_t  op_reg;
    op_t  op_next;
    res_t res_reg;
    res_t res_next;
    res_t core_res;
    logic s2_adv;
    logic s1_adv;
    logic in_acc;

    assign s2_adv   = !s2_valid_reg || out_ready;
    assign s1_adv   = s1_valid_reg && s2_adv;
    assign in_ready = !s1_valid_reg || s2_adv;
    assign in_acc   = in_valid && in_ready;

    cpu8alu_core u_core (
        .op  (op_reg),
        .res (core_res)
    );

    always_comb
    begin
        op_next         = op_reg;
        s1_valid_next   = s1_valid_reg;
        res_next        = res_reg;
        s2_valid_next   = s2_valid_reg;

        if (in_ready)
        begin
            s1_valid_next = in_valid;
        end
        if (in_acc)
        begin
            op_next.cmd     = cmd;
            op_next.acc     = acc_in;
            op_next.operand = operand_byte;
            op_next.bit_sel = bit_select;
            op_next.wide_l  = wide_left;
            op_next.wide_r  = wide_right;
            op_next.flags   = '{z: zero_in, n: sub_in, h: half_in, c: carry_in};
        end

        if (s2_adv)
        begin
            s2_valid_next = s1_valid_reg;
        end
        if (s1_adv)
        begin
            res_next = core_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        res_reg <= res_next;
    end

    assign out_valid   = s2_valid_reg;
    assign byte_result = res_reg.byte_res;
    assign byte_write  = res_reg.byte_wr;
    assign wide_result = res_reg.wide_res;
    assign zero_out    = res_reg.flags.z;
    assign sub_out     = res_reg.flags.n;
    assign half_out    = res_reg.flags.h;
    assign carry_out   = res_reg.flags.c;

    a_in_lands_s1: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> s1_valid_reg)
        else $error("accepted transaction did not reach the input register");

    a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s2_adv |=> s1_valid_reg && $stable(op_reg))
        else $error("input register dropped a blocked transaction");

    a_byte_or_wide: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && byte_write |-> wide_result == '0)
        else $error("byte write with nonzero wide result");

    a_nowrite_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !byte_write |-> byte_result == '0)
        else $error("byte result nonzero without write");

endmodule
